// File: sv/mbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg
// shared types, register indexes and compare helpers for the pattern search
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int PAT_BYTES       = 16;            // bytes held by the pattern registers
    localparam int TAP_W           = 7;             // holds taps and lengths up to 127
    localparam int CFG_IDX_W       = 3;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RESULT_LIMIT   = 3'd5;

    // window control handed to every cell
    typedef struct packed {
        logic             shift;
        logic             clear;
        logic [TAP_W-1:0] len_m1;
    } mbps_ctrl_t;

    // pattern bytes and care bits
    typedef struct packed {
        logic [8*PAT_BYTES-1:0] pattern;
        logic [PAT_BYTES-1:0]   care;
    } mbps_pat_t;

    // effective pattern length minus one: zero counts as one, saturate at max
    function automatic logic [TAP_W-1:0] eff_len_m1(input logic [4:0] len, input int max_len);
        logic [TAP_W-1:0] r;
        if (len == 5'd0) begin
            r = '0;
        end else if ({2'b00, len} > TAP_W'(max_len)) begin
            r = TAP_W'(max_len - 1);
        end else begin
            r = {2'b00, len} - TAP_W'(1);
        end
        return r;
    endfunction

    // mismatch of the byte that arrived tap steps ago against its pattern byte
    function automatic logic cmp_miss(input logic [7:0] data_byte, input logic [TAP_W-1:0] tap,
                                      input logic [TAP_W-1:0] len_m1, input mbps_pat_t pat);
        logic [TAP_W-1:0] j;
        logic [3:0]       sel;
        logic             miss;
        j    = len_m1 - tap;
        sel  = j[3:0];
        miss = 1'b0;
        if (tap <= len_m1 && j < TAP_W'(PAT_BYTES)) begin
            miss = pat.care[sel] && ((data_byte & BYTE_MASK) != pat.pattern[sel*8 +: 8]);
        end
        return miss;
    endfunction

endpackage

// File: sv/mbps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_cell
// one window byte: shifts from its neighbor and compares against its pattern byte
// ----------------------------------------------------------------------------
module mbps_cell #(
    parameter int TAP = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mbps_pkg::mbps_ctrl_t ctrl,
    input  mbps_pkg::mbps_pat_t  pat,
    input  logic [7:0]          byte_in,
    output logic [7:0]          byte_out,
    output logic                miss
);
    import mbps_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (ctrl.shift) begin
            byte_next = ctrl.clear ? 8'h00 : byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'h00;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;
    assign miss     = cmp_miss(byte_reg, TAP_W'(TAP), ctrl.len_m1, pat);

endmodule

// File: sv/masked_byte_pattern_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_top
// wildcard byte pattern search over a stream of disk bytes
// ----------------------------------------------------------------------------
// Takes one byte per clock on the s_ side while s_tready is high, and registers
// each match (overlaps included) into the output buffer. The window is
// a row of MAX_PATTERN-1 byte cells; each cell compares its byte against the
// pattern byte that lines up with it, so a whole pattern is checked in the cycle
// the last byte arrives. Results pass through a two-word output buffer (output
// register plus skid), so s_tready drops only when two results wait unread.
// Up to 16 pattern bytes come from the pattern registers; clear care bits are
// wildcards. s_tlast marks the last byte of a range: that byte may still match,
// then window, position and hit count return to zero. Reporting stops after
// result_limit matches per range; m_tlast flags the match that hits the limit.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_top #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data,
    // byte stream in
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,   // range_end
    // match stream out
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [79:0]                    m_tdata,   // [63:0] match_offset, [79:64] hit_number
    output logic                           m_tlast    // limit_reached
);
    import mbps_pkg::*;

    localparam int SEEN_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_PATTERN - 1);

    // configuration registers
    logic [63:0] start_reg;
    logic [63:0] pat_low_reg;
    logic [63:0] pat_high_reg;
    logic [15:0] care_reg;
    logic [4:0]  len_reg;
    logic [15:0] limit_reg;
    logic [63:0] base_reg;        // start offset minus (length - 1)

    // range state
    logic [SEEN_W-1:0] seen_reg;
    logic [63:0]       pos_reg;
    logic [15:0]       hits_reg;

    // output buffer
    logic        out_valid_reg;
    logic [63:0] out_offset_reg;
    logic [15:0] out_num_reg;
    logic        out_last_reg;
    logic        skid_valid_reg;
    logic [63:0] skid_offset_reg;
    logic [15:0] skid_num_reg;
    logic        skid_last_reg;

    logic             cfg_we;
    logic             accept;
    logic             pop;
    logic             hit;
    logic [TAP_W-1:0] len_m1;
    logic [15:0]      limit_eff;
    logic [63:0]      hit_offset;
    logic             hit_last;
    mbps_ctrl_t       ctrl;
    mbps_pat_t        pat;
    logic [7:0]       win [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] miss;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign pop       = out_valid_reg && m_tready;

    assign len_m1    = eff_len_m1(len_reg, MAX_PATTERN);
    assign limit_eff = (limit_reg == 16'd0) ? 16'd1 : limit_reg;

    assign ctrl.shift  = accept;
    assign ctrl.clear  = s_tlast;
    assign ctrl.len_m1 = len_m1;
    assign pat.pattern = {pat_high_reg, pat_low_reg};
    assign pat.care    = care_reg;

    // newest byte sits at tap zero, straight from the input
    assign win[0]  = s_tdata;
    assign miss[0] = cmp_miss(s_tdata, TAP_W'(0), len_m1, pat);

    // row of window cells, cell k holds the byte received k steps ago
    for (genvar k = 1; k < MAX_PATTERN; k++) begin : g_cell
        mbps_cell #(
            .TAP (k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .pat      (pat),
            .byte_in  (win[k-1]),
            .byte_out (win[k]),
            .miss     (miss[k])
        );
    end

    // full pattern in view, limit not used up, no cared byte differs
    assign hit = accept && ({{(TAP_W - SEEN_W){1'b0}}, seen_reg} >= len_m1)
               && (hits_reg < limit_eff) && !(|miss);
    assign hit_offset = base_reg + pos_reg;
    assign hit_last   = (hits_reg + 16'd1) == limit_eff;

    // configuration and range state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg    <= '0;
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= 16'hFFFF;
            len_reg      <= 5'd1;
            limit_reg    <= 16'd1;
            base_reg     <= '0;
            seen_reg     <= '0;
            pos_reg      <= '0;
            hits_reg     <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_START_OFFSET: begin
                        start_reg <= cfg_data;
                        base_reg  <= cfg_data - {{(64 - TAP_W){1'b0}}, len_m1};
                    end
                    REG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                    REG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                    REG_CARE_MASK:    care_reg     <= cfg_data[15:0];
                    REG_PATTERN_LENGTH: begin
                        len_reg  <= cfg_data[4:0];
                        base_reg <= start_reg - {{(64 - TAP_W){1'b0}},
                                                 eff_len_m1(cfg_data[4:0], MAX_PATTERN)};
                    end
                    REG_RESULT_LIMIT: limit_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (s_tlast) begin
                    seen_reg <= '0;
                    pos_reg  <= '0;
                    hits_reg <= '0;
                end else begin
                    if (seen_reg < SEEN_MAX) begin
                        seen_reg <= seen_reg + SEEN_W'(1);
                    end
                    pos_reg <= pos_reg + 64'd1;
                    if (hit) begin
                        hits_reg <= hits_reg + 16'd1;
                    end
                end
            end
        end
    end

    // two-word output buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (pop) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (hit) begin
                if (!out_valid_reg || pop) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_offset_reg <= skid_offset_reg;
                out_num_reg    <= skid_num_reg;
                out_last_reg   <= skid_last_reg;
            end
        end else if (hit) begin
            if (!out_valid_reg || pop) begin
                out_offset_reg <= hit_offset;
                out_num_reg    <= hits_reg;
                out_last_reg   <= hit_last;
            end else begin
                skid_offset_reg <= hit_offset;
                skid_num_reg    <= hits_reg;
                skid_last_reg   <= hit_last;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_num_reg, out_offset_reg};
    assign m_tlast  = out_last_reg;

    // skid word only exists behind a held output word
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    // output word is valid in the cycle after every match
    a_hit_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        hit |=> m_tvalid)
        else $error("match lost before output");

    // range end returns position, hit count and byte count to zero
    a_range_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (pos_reg == 64'd0 && hits_reg == 16'd0 && seen_reg == '0))
        else $error("range state not cleared");

    // byte count saturates below the window depth
    a_seen_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= SEEN_MAX)
        else $error("byte count past saturation");

    // no words out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("output buffer not empty after reset");

endmodule
